FILE: rtl/integer_to_ascii_radix_unit_macros.svh
// Assertion macros used by the RTL.
`ifndef INTEGER_TO_ASCII_RADIX_UNIT_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ITOA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/itoa_pkg.sv
package itoa_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int RADIX_W        = 5;
  localparam int CHAR_W         = 7;
  localparam int DIGIT_W        = 4;
  localparam int RADIX_MIN      = 2;
  localparam int RADIX_MAX      = 16;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 7'h41;

  typedef struct packed {
    logic clear;
    logic act;
    logic bit_in;
    logic shift;
  } row_ctrl_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_ALPHA + CHAR_W'(d) - CHAR_W'(10);
    end
    return c;
  endfunction

endpackage

FILE: rtl/integer_to_ascii_radix_unit.sv
// Integer to ASCII text converter, radix 2 to 16, upper-case digits.
// Request: value, radix and mode are taken at a rising edge where start is
// high and busy is low. Mode 1 reads the low VALUE_BITS bits of value as
// two's complement and prefixes a negative number with '-'.
// Results: one character per cycle on character, marked by strobe, most
// significant digit first; last is high on the final character. The
// receiver cannot stall, so each character is valid for one cycle only.
// A '-' appears in the cycle after the request is taken. The magnitude
// then shifts in MSB first through a row of VALUE_BITS radix-digit cells,
// one bit per cycle, carries rippling one cell per cycle. The digit row
// then shifts out, leading zeros suppressed, and busy stays high until
// the final character appears. A new request can be taken in the cycle
// that carries the final character. A radix outside 2 to 16 or a zero
// value gives the single character '0'.
// Reset returns the block to idle with no strobe pending.
`include "integer_to_ascii_radix_unit_macros.svh"

module integer_to_ascii_radix_unit #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [itoa_pkg::VALUE_W-1:0]  value,
  input  logic [itoa_pkg::RADIX_W-1:0]  radix,
  input  logic                          mode,
  output logic                          strobe,
  output logic [itoa_pkg::CHAR_W-1:0]   character,
  output logic                          last
);

  localparam int CNT_W = $clog2(2 * VALUE_BITS);
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(2 * VALUE_BITS - 2);
  localparam logic [CNT_W-1:0] EMIT_LAST = CNT_W'(VALUE_BITS - 1);
  localparam logic [CNT_W-1:0] FEED_LEN  = CNT_W'(VALUE_BITS);

  typedef enum logic [1:0] {IDLE, CONV, EMIT} state_t;

  state_t                         state;
  logic [CNT_W-1:0]               cnt;
  logic [VALUE_BITS-1:0]          mag;
  logic [itoa_pkg::RADIX_W-1:0]   radix_q;
  logic                           seen;

  logic [VALUE_BITS+itoa_pkg::VALUE_W-1:0] value_ext;
  logic [VALUE_BITS-1:0]          vin;
  logic [VALUE_BITS-1:0]          magnitude;
  logic                           radix_ok;
  logic                           neg;
  logic                           accept;
  logic                           digit_nz;
  logic [itoa_pkg::DIGIT_W-1:0]   top_digit;
  itoa_pkg::row_ctrl_t            ctrl;

  assign value_ext = {{VALUE_BITS{1'b0}}, value};
  assign vin       = value_ext[VALUE_BITS-1:0];
  assign radix_ok  = (radix >= itoa_pkg::RADIX_W'(itoa_pkg::RADIX_MIN)) &&
                     (radix <= itoa_pkg::RADIX_W'(itoa_pkg::RADIX_MAX));
  assign neg       = mode & vin[VALUE_BITS-1] & radix_ok;
  assign magnitude = !radix_ok ? '0 : (neg ? ('0 - vin) : vin);
  assign busy      = (state != IDLE);
  assign accept    = start & ~busy;
  assign digit_nz  = (top_digit != '0);

  assign ctrl.clear  = accept;
  assign ctrl.act    = (state == CONV) && (cnt < FEED_LEN);
  assign ctrl.bit_in = mag[VALUE_BITS-1];
  assign ctrl.shift  = (state == EMIT);

  itoa_digit_row #(
    .VALUE_BITS(VALUE_BITS)
  ) u_row (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .radix     (radix_q),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      cnt    <= '0;
      seen   <= 1'b0;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            state   <= CONV;
            cnt     <= '0;
            seen    <= 1'b0;
            mag     <= magnitude;
            radix_q <= radix_ok ? radix : itoa_pkg::RADIX_W'(itoa_pkg::RADIX_MAX);
            if (neg) begin
              strobe    <= 1'b1;
              character <= itoa_pkg::CH_MINUS;
            end
          end
        end
        CONV: begin
          mag <= {mag[VALUE_BITS-2:0], 1'b0};
          if (cnt == CONV_LAST) begin
            cnt   <= '0;
            state <= EMIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        EMIT: begin
          seen      <= seen | digit_nz;
          character <= itoa_pkg::to_ascii(top_digit);
          last      <= (cnt == EMIT_LAST);
          if (seen || digit_nz || (cnt == EMIT_LAST)) begin
            strobe <= 1'b1;
          end
          if (cnt == EMIT_LAST) begin
            cnt   <= '0;
            state <= IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `ITOA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "request taken but not busy")
  `ITOA_ASSERT_SAME(a_last_idle, clk, rst, strobe && last, !busy, "final character while busy")
  `ITOA_ASSERT_SAME(a_idle_strobe, clk, rst, !busy && strobe, last, "stray character when idle")
  `ITOA_ASSERT_SAME(a_minus_not_last, clk, rst, strobe && (character == itoa_pkg::CH_MINUS), !last, "minus sign marked last")
  `ITOA_ASSERT_NEXT(a_emit_end, clk, rst, (state == EMIT) && (cnt == EMIT_LAST), strobe && last, "no final character")

endmodule

FILE: rtl/itoa_digit_row.sv
module itoa_digit_row #(
  parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  itoa_pkg::row_ctrl_t              ctrl,
  input  logic [itoa_pkg::RADIX_W-1:0]     radix,
  output logic [itoa_pkg::DIGIT_W-1:0]     top_digit
);

  logic [itoa_pkg::DIGIT_W-1:0] digit      [VALUE_BITS];
  logic [itoa_pkg::DIGIT_W-1:0] digit_next [VALUE_BITS];
  logic [VALUE_BITS-1:0]        carry;
  logic [VALUE_BITS-1:0]        carry_next;
  logic [VALUE_BITS-1:0]        act;
  logic [VALUE_BITS:0]          cin_v;
  logic [VALUE_BITS:0]          act_v;

  assign cin_v     = {carry, ctrl.bit_in};
  assign act_v     = {act, ctrl.act};
  assign top_digit = digit[VALUE_BITS-1];

  // double each digit, add the carry from the cell below (the input bit at cell 0) and subtract radix on overflow
  always_comb begin
    logic [itoa_pkg::RADIX_W-1:0] dbl;
    logic                         ge;
    for (int i = 0; i < VALUE_BITS; i++) begin
      dbl = {digit[i], cin_v[i]};
      ge  = (dbl >= radix);
      carry_next[i] = ge;
      if (ge) begin
        digit_next[i] = itoa_pkg::DIGIT_W'(dbl - radix);
      end else begin
        digit_next[i] = dbl[itoa_pkg::DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= '0;
      act   <= '0;
    end else if (ctrl.clear) begin
      carry <= '0;
      act   <= '0;
    end else begin
      carry <= carry_next & act_v[VALUE_BITS-1:0];
      act   <= act_v[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      for (int i = 0; i < VALUE_BITS; i++) begin
        digit[i] <= '0;
      end
    end else if (ctrl.shift) begin
      digit[0] <= '0;
      for (int i = 1; i < VALUE_BITS; i++) begin
        digit[i] <= digit[i-1];
      end
    end else begin
      for (int i = 0; i < VALUE_BITS; i++) begin
        if (act_v[i]) begin
          digit[i] <= digit_next[i];
        end
      end
    end
  end

endmodule
